@@ design/cdq_pkg.sv @@
// shared types, constants and helpers for the circular deque
package cdq_pkg;

  // fixed field widths
  localparam int WORD_W = 32;
  localparam int CMD_W  = 3;
  localparam int CAP_W  = 11;

  // default ring depth and capacity after reset
  localparam int DEPTH_DEF = 1024;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // word reported while the deque is empty
  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NONE       = 3'd4;

  // input beat
  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [WORD_W-1:0] value;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
  } out_beat_t;

  // controller commands to the datapath
  typedef struct packed {
    logic exec;
    logic rd;
    logic load;
  } ctl_t;

  // saturate a capacity write into 1..depth
  function automatic int clamp_cap(logic [CAP_W-1:0] cap, int depth);
    int c;
    c = int'(cap);
    if (c < 1) begin
      c = 1;
    end
    if (c > depth) begin
      c = depth;
    end
    return c;
  endfunction

endpackage

@@ design/cdq_ctrl.sv @@
// sequencing controller for the circular deque: update, read, result load
module cdq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output cdq_pkg::ctl_t ctl
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // result register can take a new beat when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.exec  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        ctl.rd    = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          ctl.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    if (ctl.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ design/cdq_datapath.sv @@
// pointers, count, ring store and result register of the circular deque
module cdq_datapath #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cdq_pkg::ctl_t            ctl,
  input  cdq_pkg::in_beat_t        in_data,
  input  logic                     cfg_we,
  input  logic [cdq_pkg::CAP_W-1:0] cfg_data,
  output cdq_pkg::out_beat_t       out_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1) > 0 ? $clog2(DEPTH + 1) : 1;
  localparam int W     = cdq_pkg::WORD_W;

  logic [CNT_W-1:0] cap_r, cap_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [IDX_W-1:0] rear_r, rear_nxt;
  logic             ok_r, ok_nxt;

  logic [CNT_W-1:0] cap_cfg;
  logic [CNT_W-1:0] cap_rst;
  logic             full, empty;
  logic [IDX_W-1:0] front_dn, front_up, rear_dn, rear_up;
  logic [IDX_W-1:0] last_idx;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [W-1:0]     ring_mem [DEPTH];
  logic [W-1:0]     rd_front_r, rd_rear_r;
  cdq_pkg::out_beat_t out_r;

  // saturated capacity for a config write and for reset
  assign cap_cfg  = CNT_W'(cdq_pkg::clamp_cap(cfg_data, DEPTH));
  assign cap_rst  = CNT_W'(cdq_pkg::clamp_cap(cdq_pkg::CAP_RESET, DEPTH));
  assign last_idx = IDX_W'(cap_r - CNT_W'(1));

  assign full  = (cnt_r == cap_r);
  assign empty = (cnt_r == '0);

  // pointer steps with wrap at the active capacity
  assign front_dn = (front_r == '0) ? last_idx : front_r - IDX_W'(1);
  assign rear_dn  = (rear_r == '0) ? last_idx : rear_r - IDX_W'(1);
  assign front_up = (CNT_W'(front_r) + CNT_W'(1) >= cap_r) ? '0 : front_r + IDX_W'(1);
  assign rear_up  = (CNT_W'(rear_r) + CNT_W'(1) >= cap_r) ? '0 : rear_r + IDX_W'(1);

  // config write and command execution; a config write takes priority over a command
  always_comb begin
    cap_nxt   = cap_r;
    cnt_nxt   = cnt_r;
    front_nxt = front_r;
    rear_nxt  = rear_r;
    ok_nxt    = ok_r;
    wr_en     = 1'b0;
    wr_addr   = front_dn;
    if (cfg_we) begin
      cap_nxt   = cap_cfg;
      cnt_nxt   = '0;
      front_nxt = '0;
      rear_nxt  = IDX_W'(cap_cfg - CNT_W'(1));
    end else if (ctl.exec) begin
      ok_nxt = 1'b1;
      case (in_data.cmd)
        cdq_pkg::CMD_PUSH_FRONT: begin
          if (full) begin
            ok_nxt = 1'b0;
          end else begin
            front_nxt = front_dn;
            wr_en     = 1'b1;
            wr_addr   = front_dn;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end
        end
        cdq_pkg::CMD_PUSH_REAR: begin
          if (full) begin
            ok_nxt = 1'b0;
          end else begin
            rear_nxt = rear_up;
            wr_en    = 1'b1;
            wr_addr  = rear_up;
            cnt_nxt  = cnt_r + CNT_W'(1);
          end
        end
        cdq_pkg::CMD_POP_FRONT: begin
          if (empty) begin
            ok_nxt = 1'b0;
          end else begin
            front_nxt = front_up;
            cnt_nxt   = cnt_r - CNT_W'(1);
          end
        end
        cdq_pkg::CMD_POP_REAR: begin
          if (empty) begin
            ok_nxt = 1'b0;
          end else begin
            rear_nxt = rear_dn;
            cnt_nxt  = cnt_r - CNT_W'(1);
          end
        end
        default: begin
          ok_nxt = 1'b1;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= cap_rst;
      cnt_r   <= '0;
      front_r <= '0;
      rear_r  <= IDX_W'(cap_rst - CNT_W'(1));
      ok_r    <= 1'b1;
    end else begin
      cap_r   <= cap_nxt;
      cnt_r   <= cnt_nxt;
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      ok_r    <= ok_nxt;
    end
  end

  // ring store, one write and two registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= in_data.value;
    end
    if (ctl.rd) begin
      rd_front_r <= ring_mem[front_r];
      rd_rear_r  <= ring_mem[rear_r];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      out_r.ok          <= ok_r;
      out_r.front_value <= empty ? cdq_pkg::EMPTY_WORD : rd_front_r;
      out_r.rear_value  <= empty ? cdq_pkg::EMPTY_WORD : rd_rear_r;
      out_r.is_empty    <= empty;
      out_r.is_full     <= full;
    end
  end

  assign out_data = out_r;

endmodule

@@ design/circular_deque_ring_buffer.sv @@
// circular deque: each beat runs through update and store write, store read and result load,
// in that order; a new beat is accepted only after the last one is loaded, and the load waits
// while a held result still fills the output register. the result waits in an output register;
// the next beat is taken while it waits. reset (rst_n low, synchronous) empties the
// deque with capacity 1024 saturated to DEPTH; store contents are not cleared.
module circular_deque_ring_buffer #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  cdq_pkg::in_beat_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output cdq_pkg::out_beat_t        out_data,
  input  logic                      cfg_we,
  input  logic [cdq_pkg::CAP_W-1:0] cfg_data
);

  cdq_pkg::ctl_t ctl;

  // sequencing
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // pointers, store and result
  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule
